// ----- rtl/sample_statistics_accumulator_unit_assert.svh -----
// Assertion macros used by the accumulator unit.
`ifndef SAMPLE_STATISTICS_ACCUMULATOR_UNIT_ASSERT_SVH
`define SAMPLE_STATISTICS_ACCUMULATOR_UNIT_ASSERT_SVH

// Same-cycle implication under a synchronous active-low reset.
`define SSA_AP_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// Next-cycle implication under a synchronous active-low reset.
`define SSA_AP_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

// ----- rtl/ssa_pkg.sv -----
package ssa_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int COUNT_MAX   = 65536;
    localparam int FRAC_BITS   = 8;

    localparam int CNT_W  = $clog2(COUNT_MAX + 1);
    localparam int SX_W   = SAMPLE_BITS + CNT_W;
    localparam int SQ_W   = 2 * SAMPLE_BITS + CNT_W - 2;
    localparam int PROD_W = 2 * SAMPLE_BITS + CNT_W - 1;

    localparam int WORD_W = 64;
    localparam int DVD_W  = WORD_W + FRAC_BITS;
    localparam int RAD_W  = 48;
    localparam int STEP_W = $clog2(DVD_W);

    localparam int MUL_STEPS  = WORD_W;
    localparam int DIV_STEPS  = DVD_W;
    localparam int SQRT_STEPS = RAD_W / 2;

    localparam int OCNT_W = 17;
    localparam int OSUM_W = 32;
    localparam int MEAN_W = 24;
    localparam int VAR_W  = 39;
    localparam int UVAR_W = 40;
    localparam int STD_W  = 24;
    localparam int COV_W  = 40;

    localparam logic [1:0] OP_MUL  = 2'd0;
    localparam logic [1:0] OP_DIV  = 2'd1;
    localparam logic [1:0] OP_SQRT = 2'd2;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample_x;
        logic signed [SAMPLE_BITS-1:0] sample_y;
        logic                          has_sample;
        logic                          last_sample;
    } t_in;

    typedef struct packed {
        logic        [OCNT_W-1:0]      sample_count;
        logic signed [OSUM_W-1:0]      sum_x;
        logic signed [MEAN_W-1:0]      mean_x;
        logic signed [MEAN_W-1:0]      mean_y;
        logic        [VAR_W-1:0]       variance_x;
        logic        [UVAR_W-1:0]      unbiased_variance_x;
        logic        [STD_W-1:0]       std_dev_x;
        logic signed [COV_W-1:0]       covariance_xy;
        logic signed [SAMPLE_BITS-1:0] max_x;
        logic signed [SAMPLE_BITS-1:0] min_x;
        logic                          set_empty;
    } t_out;

    typedef struct packed {
        logic              start;
        logic [1:0]        op;
        logic [DVD_W-1:0]  a;
        logic [WORD_W-1:0] b;
    } t_unit_req;

    typedef struct packed {
        logic             done;
        logic [DVD_W-1:0] res;
        logic             rem_nz;
    } t_unit_rsp;

endpackage

// ----- rtl/sample_statistics_accumulator_unit.sv -----
// Sample statistics accumulator.
// Input channel (i_in_valid / o_in_ready / i_in_data) carries one beat per
// item: a signed (x, y) pair, a has_sample flag and a last_sample flag.
// Samples are folded into the count, sums, sum of squares, sum of products
// and the running extremes of x in the cycle their beat is accepted, so a
// stream of non-closing beats goes in at one beat per clock.
// A beat with last_sample set closes the set. The block then drops ready
// and runs the closing math on one shared shift-add multiplier, restoring
// divider and square-root unit: five 64-step multiplies, up to five
// 72-step divides and a 24-step root; a set of under two samples skips
// the unbiased-variance divide and an empty set skips all of the math.
// The result beat is then placed in the output register (o_out_valid /
// i_out_ready / o_out_data), the accumulators clear, and ready returns.
// A stalled receiver leaves the result held in the output register while
// the block keeps accepting samples for the next set; a second closing
// result waits in the sequencer until the first one is taken.
// Reset (i_rst_n low, synchronous) clears the accumulators, the sequencer
// and the output valid flag.
module sample_statistics_accumulator_unit
    import ssa_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_data
);

    `include "sample_statistics_accumulator_unit_assert.svh"

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_CHK   = 4'd1;
    localparam logic [3:0] ST_NSXX  = 4'd2;
    localparam logic [3:0] ST_SXSX  = 4'd3;
    localparam logic [3:0] ST_NSXY  = 4'd4;
    localparam logic [3:0] ST_SXSY  = 4'd5;
    localparam logic [3:0] ST_NN    = 4'd6;
    localparam logic [3:0] ST_VAR   = 4'd7;
    localparam logic [3:0] ST_UVAR  = 4'd8;
    localparam logic [3:0] ST_COV   = 4'd9;
    localparam logic [3:0] ST_MX    = 4'd10;
    localparam logic [3:0] ST_MY    = 4'd11;
    localparam logic [3:0] ST_SQRT  = 4'd12;
    localparam logic [3:0] ST_OUT   = 4'd13;

    // Accumulators for the open set.
    logic        [CNT_W-1:0]       r_count, n_count;
    logic signed [SX_W-1:0]        r_sum_x, n_sum_x;
    logic signed [SX_W-1:0]        r_sum_y, n_sum_y;
    logic        [SQ_W-1:0]        r_sum_sq, n_sum_sq;
    logic signed [PROD_W-1:0]      r_sum_prod, n_sum_prod;
    logic signed [SAMPLE_BITS-1:0] r_max, n_max;
    logic signed [SAMPLE_BITS-1:0] r_min, n_min;

    // Closing sequencer and its intermediate products.
    logic [3:0]        r_state, n_state;
    logic              r_issued, n_issued;
    logic [WORD_W-1:0] r_p, n_p;
    logic [WORD_W-1:0] r_d, n_d;
    logic [WORD_W-1:0] r_c, n_c;
    logic [WORD_W-1:0] r_n2, n_n2;
    t_out              r_res, n_res;
    t_out              r_out, n_out;
    logic              r_out_valid, n_out_valid;

    logic                            w_in_fire;
    logic                            w_take;
    logic                            w_start;
    logic signed [2*SAMPLE_BITS-1:0] w_xx;
    logic signed [2*SAMPLE_BITS-1:0] w_xy;
    logic signed [WORD_W-1:0]        w_sx64;
    logic signed [WORD_W-1:0]        w_sy64;
    logic        [WORD_W-1:0]        w_n64;
    logic        [WORD_W-1:0]        w_abs_sx;
    logic        [WORD_W-1:0]        w_abs_sy;
    logic        [WORD_W-1:0]        w_abs_c;
    logic        [DVD_W-1:0]         w_sres;
    logic                            w_sneg;
    t_unit_req                       w_req;
    t_unit_rsp                       w_rsp;

    assign o_in_ready = (r_state == ST_IDLE);
    assign w_in_fire  = i_in_valid && o_in_ready;
    assign w_take     = w_in_fire && i_in_data.has_sample && (r_count < CNT_W'(COUNT_MAX));

    // Per-sample products; each feeds only one accumulator add.
    assign w_xx = i_in_data.sample_x * i_in_data.sample_x;
    assign w_xy = i_in_data.sample_x * i_in_data.sample_y;

    assign w_sx64   = WORD_W'(r_sum_x);
    assign w_sy64   = WORD_W'(r_sum_y);
    assign w_n64    = WORD_W'(r_count);
    assign w_abs_sx = w_sx64[WORD_W-1] ? WORD_W'(-w_sx64) : WORD_W'(w_sx64);
    assign w_abs_sy = w_sy64[WORD_W-1] ? WORD_W'(-w_sy64) : WORD_W'(w_sy64);
    assign w_abs_c  = r_c[WORD_W-1] ? (~r_c + 1'b1) : r_c;

    // A divide of a magnitude gives a floor; a negative numerator turns the
    // floor of the magnitude into minus its ceiling.
    always_comb begin
        case (r_state)
            ST_COV:  w_sneg = r_c[WORD_W-1];
            ST_MX:   w_sneg = w_sx64[WORD_W-1];
            ST_MY:   w_sneg = w_sy64[WORD_W-1];
            default: w_sneg = 1'b0;
        endcase
        if (w_sneg) begin
            w_sres = ~(w_rsp.res + DVD_W'(w_rsp.rem_nz)) + 1'b1;
        end else begin
            w_sres = w_rsp.res;
        end
    end

    // Operands for the shared unit in each closing step.
    always_comb begin
        w_req.start = w_start;
        w_req.op    = OP_MUL;
        w_req.a     = '0;
        w_req.b     = '0;
        case (r_state)
            ST_NSXX: begin
                w_req.a = DVD_W'(r_count);
                w_req.b = WORD_W'(r_sum_sq);
            end
            ST_SXSX: begin
                w_req.a = {{(DVD_W-WORD_W){1'b0}}, w_sx64};
                w_req.b = w_sx64;
            end
            ST_NSXY: begin
                w_req.a = DVD_W'(r_count);
                w_req.b = WORD_W'(r_sum_prod);
            end
            ST_SXSY: begin
                w_req.a = {{(DVD_W-WORD_W){1'b0}}, w_sx64};
                w_req.b = w_sy64;
            end
            ST_NN: begin
                w_req.a = DVD_W'(r_count);
                w_req.b = w_n64;
            end
            ST_VAR: begin
                w_req.op = OP_DIV;
                w_req.a  = {r_d, {FRAC_BITS{1'b0}}};
                w_req.b  = r_n2;
            end
            ST_UVAR: begin
                w_req.op = OP_DIV;
                w_req.a  = {r_d, {FRAC_BITS{1'b0}}};
                w_req.b  = r_n2 - w_n64;
            end
            ST_COV: begin
                w_req.op = OP_DIV;
                w_req.a  = {w_abs_c, {FRAC_BITS{1'b0}}};
                w_req.b  = r_n2;
            end
            ST_MX: begin
                w_req.op = OP_DIV;
                w_req.a  = {w_abs_sx, {FRAC_BITS{1'b0}}};
                w_req.b  = w_n64;
            end
            ST_MY: begin
                w_req.op = OP_DIV;
                w_req.a  = {w_abs_sy, {FRAC_BITS{1'b0}}};
                w_req.b  = w_n64;
            end
            ST_SQRT: begin
                w_req.op = OP_SQRT;
                w_req.a  = DVD_W'({r_res.variance_x, {FRAC_BITS{1'b0}}});
            end
            default: begin
                w_req.op = OP_MUL;
            end
        endcase
    end

    always_comb begin
        n_count     = r_count;
        n_sum_x     = r_sum_x;
        n_sum_y     = r_sum_y;
        n_sum_sq    = r_sum_sq;
        n_sum_prod  = r_sum_prod;
        n_max       = r_max;
        n_min       = r_min;
        n_state     = r_state;
        n_issued    = r_issued;
        n_p         = r_p;
        n_d         = r_d;
        n_c         = r_c;
        n_n2        = r_n2;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;
        w_start     = 1'b0;

        if (w_take) begin
            // The first sample of a set replaces both extremes.
            if (r_count == '0) begin
                n_max = i_in_data.sample_x;
                n_min = i_in_data.sample_x;
            end else begin
                if (i_in_data.sample_x > r_max) n_max = i_in_data.sample_x;
                if (i_in_data.sample_x < r_min) n_min = i_in_data.sample_x;
            end
            n_count    = r_count + 1'b1;
            n_sum_x    = r_sum_x + SX_W'(i_in_data.sample_x);
            n_sum_y    = r_sum_y + SX_W'(i_in_data.sample_y);
            n_sum_sq   = r_sum_sq + SQ_W'(unsigned'(w_xx));
            n_sum_prod = r_sum_prod + PROD_W'(w_xy);
        end

        // Each step but a skipped UVAR issues one request and waits for done.
        if (r_state != ST_IDLE && r_state != ST_CHK && r_state != ST_OUT) begin
            if (r_state == ST_UVAR && r_count < CNT_W'(2)) begin
                n_res.unbiased_variance_x = '0;
                n_state = ST_COV;
            end else if (!r_issued) begin
                w_start  = 1'b1;
                n_issued = 1'b1;
            end
        end

        case (r_state)
            ST_IDLE: begin
                if (w_in_fire && i_in_data.last_sample) n_state = ST_CHK;
            end
            ST_CHK: begin
                n_res = '0;
                if (r_count == '0) begin
                    n_res.set_empty = 1'b1;
                    n_state = ST_OUT;
                end else begin
                    n_res.sample_count = OCNT_W'(r_count);
                    n_res.sum_x        = OSUM_W'(r_sum_x);
                    n_res.max_x        = r_max;
                    n_res.min_x        = r_min;
                    n_state            = ST_NSXX;
                end
            end
            ST_NSXX: begin
                if (w_rsp.done) begin
                    n_p = w_rsp.res[WORD_W-1:0];
                    n_issued = 1'b0;
                    n_state = ST_SXSX;
                end
            end
            ST_SXSX: begin
                if (w_rsp.done) begin
                    n_d = r_p - w_rsp.res[WORD_W-1:0];
                    // Clamp a negative variance numerator at zero.
                    if (n_d[WORD_W-1]) n_d = '0;
                    n_issued = 1'b0;
                    n_state = ST_NSXY;
                end
            end
            ST_NSXY: begin
                if (w_rsp.done) begin
                    n_p = w_rsp.res[WORD_W-1:0];
                    n_issued = 1'b0;
                    n_state = ST_SXSY;
                end
            end
            ST_SXSY: begin
                if (w_rsp.done) begin
                    n_c = r_p - w_rsp.res[WORD_W-1:0];
                    n_issued = 1'b0;
                    n_state = ST_NN;
                end
            end
            ST_NN: begin
                if (w_rsp.done) begin
                    n_n2 = w_rsp.res[WORD_W-1:0];
                    n_issued = 1'b0;
                    n_state = ST_VAR;
                end
            end
            ST_VAR: begin
                if (w_rsp.done) begin
                    n_res.variance_x = w_rsp.res[VAR_W-1:0];
                    n_issued = 1'b0;
                    n_state = ST_UVAR;
                end
            end
            ST_UVAR: begin
                if (w_rsp.done) begin
                    n_res.unbiased_variance_x = w_rsp.res[UVAR_W-1:0];
                    n_issued = 1'b0;
                    n_state = ST_COV;
                end
            end
            ST_COV: begin
                if (w_rsp.done) begin
                    n_res.covariance_xy = w_sres[COV_W-1:0];
                    n_issued = 1'b0;
                    n_state = ST_MX;
                end
            end
            ST_MX: begin
                if (w_rsp.done) begin
                    n_res.mean_x = w_sres[MEAN_W-1:0];
                    n_issued = 1'b0;
                    n_state = ST_MY;
                end
            end
            ST_MY: begin
                if (w_rsp.done) begin
                    n_res.mean_y = w_sres[MEAN_W-1:0];
                    n_issued = 1'b0;
                    n_state = ST_SQRT;
                end
            end
            ST_SQRT: begin
                if (w_rsp.done) begin
                    n_res.std_dev_x = w_rsp.res[STD_W-1:0];
                    n_issued = 1'b0;
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                // Hand the result to the output register once it is free,
                // then open a fresh set.
                if (!r_out_valid || i_out_ready) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_count     = '0;
                    n_sum_x     = '0;
                    n_sum_y     = '0;
                    n_sum_sq    = '0;
                    n_sum_prod  = '0;
                    n_max       = '0;
                    n_min       = '0;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_sum_x     <= '0;
            r_sum_y     <= '0;
            r_sum_sq    <= '0;
            r_sum_prod  <= '0;
            r_max       <= '0;
            r_min       <= '0;
            r_state     <= ST_IDLE;
            r_issued    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_sum_x     <= n_sum_x;
            r_sum_y     <= n_sum_y;
            r_sum_sq    <= n_sum_sq;
            r_sum_prod  <= n_sum_prod;
            r_max       <= n_max;
            r_min       <= n_min;
            r_state     <= n_state;
            r_issued    <= n_issued;
            r_out_valid <= n_out_valid;
        end
        r_p   <= n_p;
        r_d   <= n_d;
        r_c   <= n_c;
        r_n2  <= n_n2;
        r_res <= n_res;
        r_out <= n_out;
    end

    ssa_shared_unit u_unit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // The sample count never passes its ceiling.
    `SSA_AP_IMPL(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(COUNT_MAX))
    // A closing beat always starts the closing sequence.
    `SSA_AP_NEXT(a_close_starts, i_clk, i_rst_n, w_in_fire && i_in_data.last_sample, r_state == ST_CHK)
    // The shared unit only reports completion of a request that was issued.
    `SSA_AP_IMPL(a_done_issued, i_clk, i_rst_n, w_rsp.done, r_issued)

endmodule

// ----- rtl/ssa_shared_unit.sv -----
module ssa_shared_unit
    import ssa_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_unit_req i_req,
    output t_unit_rsp o_rsp
);

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [1:0]        r_op, n_op;
    logic [STEP_W-1:0] r_cnt, n_cnt;
    logic [DVD_W-1:0]  r_acc, n_acc;
    logic [DVD_W-1:0]  r_x, n_x;
    logic [WORD_W-1:0] r_y, n_y;
    logic [WORD_W:0]   r_rem, n_rem;

    logic [WORD_W:0]   w_dsh;
    logic [WORD_W+1:0] w_ddiff;
    logic [WORD_W:0]   w_ssh;
    logic [WORD_W:0]   w_strial;
    logic [WORD_W+1:0] w_sdiff;

    // Restoring division: one quotient bit per step.
    assign w_dsh   = {r_rem[WORD_W-1:0], r_x[DVD_W-1]};
    assign w_ddiff = {1'b0, w_dsh} - {2'b00, r_y};
    // Digit-by-digit square root: two radicand bits per step.
    assign w_ssh    = {r_rem[WORD_W-2:0], r_x[RAD_W-1:RAD_W-2]};
    assign w_strial = {r_acc[WORD_W-2:0], 2'b01};
    assign w_sdiff  = {1'b0, w_ssh} - {1'b0, w_strial};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_op   = r_op;
        n_cnt  = r_cnt;
        n_acc  = r_acc;
        n_x    = r_x;
        n_y    = r_y;
        n_rem  = r_rem;
        if (!r_busy) begin
            if (i_req.start) begin
                n_busy = 1'b1;
                n_op   = i_req.op;
                n_rem  = '0;
                n_acc  = '0;
                n_x    = i_req.a;
                n_y    = i_req.b;
                case (i_req.op)
                    OP_MUL:  n_cnt = STEP_W'(MUL_STEPS - 1);
                    OP_DIV:  n_cnt = STEP_W'(DIV_STEPS - 1);
                    OP_SQRT: n_cnt = STEP_W'(SQRT_STEPS - 1);
                    default: n_busy = 1'b0;
                endcase
            end
        end else begin
            case (r_op)
                OP_MUL: begin
                    if (r_y[0]) begin
                        n_acc = {{(DVD_W-WORD_W){1'b0}}, r_acc[WORD_W-1:0] + r_x[WORD_W-1:0]};
                    end
                    n_x = {r_x[DVD_W-2:0], 1'b0};
                    n_y = {1'b0, r_y[WORD_W-1:1]};
                end
                OP_DIV: begin
                    if (!w_ddiff[WORD_W+1]) begin
                        n_rem = w_ddiff[WORD_W:0];
                        n_x   = {r_x[DVD_W-2:0], 1'b1};
                    end else begin
                        n_rem = w_dsh;
                        n_x   = {r_x[DVD_W-2:0], 1'b0};
                    end
                end
                OP_SQRT: begin
                    if (!w_sdiff[WORD_W+1]) begin
                        n_rem = w_sdiff[WORD_W:0];
                        n_acc = {r_acc[DVD_W-2:0], 1'b1};
                    end else begin
                        n_rem = w_ssh;
                        n_acc = {r_acc[DVD_W-2:0], 1'b0};
                    end
                    n_x = {r_x[DVD_W-3:0], 2'b00};
                end
                default: n_busy = 1'b0;
            endcase
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end else begin
                n_cnt = r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_op   <= OP_MUL;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_op   <= n_op;
            r_cnt  <= n_cnt;
        end
        r_acc <= n_acc;
        r_x   <= n_x;
        r_y   <= n_y;
        r_rem <= n_rem;
    end

    assign o_rsp.done   = r_done;
    assign o_rsp.res    = (r_op == OP_DIV) ? r_x : r_acc;
    assign o_rsp.rem_nz = |r_rem;

endmodule
